### src/fds_pkg.sv
// Package for the data stack engine: sizes, codes, entry and request/response types.
// Used by every other source file but fds_ram; depends on nothing.
`default_nettype none

package fds_pkg;

    // Stack size and entry width.
    localparam int STACK_DEPTH = 64;
    localparam int VALUE_WIDTH = 32;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ENTRY_W     = VALUE_WIDTH + 1;

    // Fixed widths of the request and response fields.
    localparam int ACT_W   = 4;
    localparam int FIELD_W = 32;
    localparam int DEPTH_W = 7;
    localparam int ERR_W   = 3;

    // Stack words.
    typedef enum logic [ACT_W-1:0] {
        ACT_PUSH  = 4'd0,
        ACT_DUP   = 4'd1,
        ACT_DROP  = 4'd2,
        ACT_SWAP  = 4'd3,
        ACT_OVER  = 4'd4,
        ACT_ROT   = 4'd5,
        ACT_PICK  = 4'd6,
        ACT_ROLL  = 4'd7,
        ACT_CLEAR = 4'd8,
        ACT_DEPTH = 4'd9
    } t_action;

    // Error codes reported with every response.
    typedef enum logic [ERR_W-1:0] {
        ERR_OK     = 3'd0,
        ERR_UNDER  = 3'd1,
        ERR_NOTNUM = 3'd2,
        ERR_BOUNDS = 3'd3,
        ERR_OVER   = 3'd4
    } t_err;

    // Sequencer states of the engine.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_LOAD_TOP,
        ST_SWAP,
        ST_ROT_A,
        ST_ROT_B,
        ST_COPY,
        ST_ROLL_GET,
        ST_ROLL_SHIFT,
        ST_WR_HOLD,
        ST_DONE
    } t_state;

    // One stack entry: tag above the value.
    typedef struct packed {
        logic                   tag;
        logic [VALUE_WIDTH-1:0] value;
    } t_entry;

    // Request and response payloads.
    typedef struct packed {
        logic [ACT_W-1:0]          action;
        logic signed [FIELD_W-1:0] push_value;
        logic                      push_is_number;
    } t_req;

    typedef struct packed {
        logic signed [FIELD_W-1:0] top_value;
        logic                      top_is_number;
        logic [DEPTH_W-1:0]        stack_depth;
        logic [ERR_W-1:0]          error_code;
    } t_rsp;

    // Sign-extends a pushed field value and keeps the stored width.
    function automatic logic [VALUE_WIDTH-1:0] to_value(input logic signed [FIELD_W-1:0] v);
        logic signed [63:0] w;
        w = 64'(v);
        return w[VALUE_WIDTH-1:0];
    endfunction

    // Sign-extends a stored value and keeps the response field width.
    function automatic logic [FIELD_W-1:0] to_field(input logic [VALUE_WIDTH-1:0] v);
        logic signed [63:0] w;
        w = 64'(signed'(v));
        return w[FIELD_W-1:0];
    endfunction

endpackage

`default_nettype wire

### src/fds_ifs.sv
// Request and response channel interfaces of the data stack engine.
// Depends on fds_pkg for the payload types.
`default_nettype none

interface fds_req_if;
    logic          valid;
    logic          ready;
    fds_pkg::t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface fds_rsp_if;
    logic          valid;
    logic          ready;
    fds_pkg::t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### src/fds_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Stand-alone; depends on nothing.
`default_nettype none

module fds_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### src/forth_style_data_stack_engine.sv
// Top level of the data stack engine: word sequencer, top-of-stack cache and output register.
// Depends on fds_pkg, fds_ifs (fds_req_if, fds_rsp_if) and fds_ram.
//
// Each request carries one stack word; the engine answers with exactly one response that
// holds the new top entry, the depth and an error code. The stack lives in a 64-entry RAM
// with one write and one read port and a registered read; the top entry is also kept in a
// register. One request is worked on at a time and the next is taken once it is finished.
// Push, DUP, DEPTH, CLEAR, a DROP that empties the stack, unused codes and every error
// finish in EXEC; DROP, OVER, PICK, SWAP, ROT and ROLL go on through further states. The
// single RAM write port sets these: every entry that moves is written in its own step. A
// finished response waits in the output register; the engine then takes the next request
// at once, but can only finish it once that register is free.
`default_nettype none

module forth_style_data_stack_engine (
    input wire logic  i_clk,
    input wire logic  i_rst_n,
    fds_req_if.sink   i_req,
    fds_rsp_if.source o_rsp
);

    localparam int AW = fds_pkg::ADDR_W;
    localparam int CW = fds_pkg::CNT_W;
    localparam int VW = fds_pkg::VALUE_WIDTH;

    fds_pkg::t_state r_state, n_state;

    // Latched request.
    logic [fds_pkg::ACT_W-1:0]          r_act;
    logic signed [fds_pkg::FIELD_W-1:0] r_pv;
    logic                               r_ptag;

    // Stack bookkeeping.
    logic [CW-1:0]    r_count, n_count;
    fds_pkg::t_entry  r_top, n_top;
    fds_pkg::t_entry  r_hold, n_hold;
    fds_pkg::t_err    r_err, n_err;
    logic [AW-1:0]    r_ptr, n_ptr;
    logic [AW-1:0]    r_wa, n_wa;
    logic [AW-1:0]    r_last, n_last;

    // Output register.
    logic            r_ov;
    fds_pkg::t_rsp   r_rsp;
    fds_pkg::t_rsp   rsp_next;
    logic            emit;
    logic            out_free;

    // RAM port.
    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [AW-1:0]   ram_raddr;
    fds_pkg::t_entry ram_wdata;
    fds_pkg::t_entry ram_rdata;

    // Decode of the request under way.
    fds_pkg::t_err   d_err;
    logic            d_single;
    logic            c_full;
    logic [CW-1:0]   below;
    logic            idx_oob;
    logic [AW-1:0]   d_src;
    fds_pkg::t_entry push_entry;
    fds_pkg::t_entry depth_entry;

    fds_ram #(
        .WIDTH (fds_pkg::ENTRY_W),
        .DEPTH (fds_pkg::STACK_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign out_free = !r_ov || o_rsp.ready;

    // Index check for PICK and ROLL, and the position of the chosen entry.
    always_comb begin
        c_full  = r_count >= CW'(fds_pkg::STACK_DEPTH);
        below   = r_count - CW'(1);
        idx_oob = r_top.value[VW-1]
                  || ({CW'(0), r_top.value} >= {VW'(0), below});
        d_src   = AW'(below - CW'(1)) - AW'(r_top.value);
        push_entry.tag    = r_ptag;
        push_entry.value  = fds_pkg::to_value(r_pv);
        depth_entry.tag   = 1'b1;
        depth_entry.value = VW'(r_count);
    end

    // Error code and whether the word finishes in EXEC.
    always_comb begin
        d_err = fds_pkg::ERR_OK;
        case (r_act)
            fds_pkg::ACT_PUSH, fds_pkg::ACT_DEPTH: begin
                if (c_full) d_err = fds_pkg::ERR_OVER;
            end
            fds_pkg::ACT_DUP: begin
                if (r_count < CW'(1)) d_err = fds_pkg::ERR_UNDER;
                else if (c_full)      d_err = fds_pkg::ERR_OVER;
            end
            fds_pkg::ACT_DROP: begin
                if (r_count < CW'(1)) d_err = fds_pkg::ERR_UNDER;
            end
            fds_pkg::ACT_SWAP: begin
                if (r_count < CW'(2)) d_err = fds_pkg::ERR_UNDER;
            end
            fds_pkg::ACT_OVER: begin
                if (r_count < CW'(2)) d_err = fds_pkg::ERR_UNDER;
                else if (c_full)      d_err = fds_pkg::ERR_OVER;
            end
            fds_pkg::ACT_ROT: begin
                if (r_count < CW'(3)) d_err = fds_pkg::ERR_UNDER;
            end
            fds_pkg::ACT_PICK, fds_pkg::ACT_ROLL: begin
                if (r_count < CW'(1)) d_err = fds_pkg::ERR_UNDER;
                else if (!r_top.tag)  d_err = fds_pkg::ERR_NOTNUM;
                else if (idx_oob)     d_err = fds_pkg::ERR_BOUNDS;
            end
            default: d_err = fds_pkg::ERR_OK;
        endcase

        case (r_act)
            fds_pkg::ACT_DROP: d_single = r_count == CW'(1);
            fds_pkg::ACT_SWAP, fds_pkg::ACT_OVER, fds_pkg::ACT_ROT,
            fds_pkg::ACT_PICK, fds_pkg::ACT_ROLL: d_single = 1'b0;
            default: d_single = 1'b1;
        endcase
        if (d_err != fds_pkg::ERR_OK) d_single = 1'b1;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            fds_pkg::ST_IDLE: begin
                if (i_req.valid) n_state = fds_pkg::ST_EXEC;
            end
            fds_pkg::ST_EXEC: begin
                if (d_single) begin
                    n_state = out_free ? fds_pkg::ST_IDLE : fds_pkg::ST_DONE;
                end else begin
                    case (r_act)
                        fds_pkg::ACT_DROP: n_state = fds_pkg::ST_LOAD_TOP;
                        fds_pkg::ACT_SWAP: n_state = fds_pkg::ST_SWAP;
                        fds_pkg::ACT_ROT:  n_state = fds_pkg::ST_ROT_A;
                        fds_pkg::ACT_ROLL: n_state = fds_pkg::ST_ROLL_GET;
                        default:           n_state = fds_pkg::ST_COPY;
                    endcase
                end
            end
            fds_pkg::ST_SWAP:  n_state = fds_pkg::ST_WR_HOLD;
            fds_pkg::ST_ROT_A: n_state = fds_pkg::ST_ROT_B;
            fds_pkg::ST_ROT_B: n_state = fds_pkg::ST_WR_HOLD;
            fds_pkg::ST_ROLL_GET: begin
                n_state = (r_ptr == r_last) ? fds_pkg::ST_WR_HOLD : fds_pkg::ST_ROLL_SHIFT;
            end
            fds_pkg::ST_ROLL_SHIFT: begin
                if (r_ptr + AW'(1) == r_last) n_state = fds_pkg::ST_WR_HOLD;
            end
            fds_pkg::ST_LOAD_TOP, fds_pkg::ST_COPY, fds_pkg::ST_WR_HOLD, fds_pkg::ST_DONE: begin
                n_state = out_free ? fds_pkg::ST_IDLE : fds_pkg::ST_DONE;
            end
            default: n_state = fds_pkg::ST_IDLE;
        endcase
    end

    // Datapath controls: RAM accesses, bookkeeping updates and response hand-off.
    always_comb begin
        n_count   = r_count;
        n_top     = r_top;
        n_hold    = r_hold;
        n_err     = r_err;
        n_ptr     = r_ptr;
        n_wa      = r_wa;
        n_last    = r_last;
        ram_we    = 1'b0;
        ram_waddr = r_wa;
        ram_wdata = r_hold;
        ram_raddr = r_ptr;
        emit      = 1'b0;
        case (r_state)
            fds_pkg::ST_EXEC: begin
                n_err  = d_err;
                n_hold = r_top;
                n_last = AW'(r_count - CW'(2));
                emit   = d_single && out_free;
                if (d_err == fds_pkg::ERR_OK) begin
                    case (r_act)
                        fds_pkg::ACT_PUSH: begin
                            ram_we    = 1'b1;
                            ram_waddr = AW'(r_count);
                            ram_wdata = push_entry;
                            n_top     = push_entry;
                            n_count   = r_count + CW'(1);
                        end
                        fds_pkg::ACT_DUP: begin
                            ram_we    = 1'b1;
                            ram_waddr = AW'(r_count);
                            ram_wdata = r_top;
                            n_count   = r_count + CW'(1);
                        end
                        fds_pkg::ACT_DROP: begin
                            ram_raddr = AW'(r_count - CW'(2));
                            n_count   = r_count - CW'(1);
                        end
                        fds_pkg::ACT_SWAP: begin
                            ram_raddr = AW'(r_count - CW'(2));
                        end
                        fds_pkg::ACT_OVER: begin
                            ram_raddr = AW'(r_count - CW'(2));
                            n_wa      = AW'(r_count);
                            n_count   = r_count + CW'(1);
                        end
                        fds_pkg::ACT_ROT: begin
                            ram_raddr = AW'(r_count - CW'(3));
                        end
                        fds_pkg::ACT_PICK: begin
                            ram_raddr = d_src;
                            n_wa      = AW'(r_count - CW'(1));
                        end
                        fds_pkg::ACT_ROLL: begin
                            ram_raddr = d_src;
                            n_ptr     = d_src;
                            n_count   = r_count - CW'(1);
                        end
                        fds_pkg::ACT_CLEAR: begin
                            n_count = '0;
                        end
                        fds_pkg::ACT_DEPTH: begin
                            ram_we    = 1'b1;
                            ram_waddr = AW'(r_count);
                            ram_wdata = depth_entry;
                            n_top     = depth_entry;
                            n_count   = r_count + CW'(1);
                        end
                        default: n_count = r_count;
                    endcase
                end
            end
            fds_pkg::ST_LOAD_TOP: begin
                n_top = ram_rdata;
                emit  = out_free;
            end
            // The second entry goes on top; the old top follows into its place.
            fds_pkg::ST_SWAP: begin
                ram_we    = 1'b1;
                ram_waddr = r_last + AW'(1);
                ram_wdata = ram_rdata;
                n_top     = ram_rdata;
            end
            // Third entry goes on top while the second is fetched.
            fds_pkg::ST_ROT_A: begin
                ram_we    = 1'b1;
                ram_waddr = r_last + AW'(1);
                ram_wdata = ram_rdata;
                n_top     = ram_rdata;
                ram_raddr = r_last;
            end
            fds_pkg::ST_ROT_B: begin
                ram_we    = 1'b1;
                ram_waddr = r_last - AW'(1);
                ram_wdata = ram_rdata;
            end
            fds_pkg::ST_COPY: begin
                ram_we    = 1'b1;
                ram_waddr = r_wa;
                ram_wdata = ram_rdata;
                n_top     = ram_rdata;
                emit      = out_free;
            end
            // The chosen entry is held and becomes the new top.
            fds_pkg::ST_ROLL_GET: begin
                n_hold    = ram_rdata;
                n_top     = ram_rdata;
                ram_raddr = r_ptr + AW'(1);
            end
            // Each entry above the chosen one moves down by one, one per cycle.
            fds_pkg::ST_ROLL_SHIFT: begin
                ram_we    = 1'b1;
                ram_waddr = r_ptr;
                ram_wdata = ram_rdata;
                ram_raddr = r_ptr + AW'(2);
                n_ptr     = r_ptr + AW'(1);
            end
            fds_pkg::ST_WR_HOLD: begin
                ram_we    = 1'b1;
                ram_waddr = r_last;
                ram_wdata = r_hold;
                emit      = out_free;
            end
            fds_pkg::ST_DONE: begin
                emit = out_free;
            end
            default: emit = 1'b0;
        endcase
    end

    // Response built from the state after the word.
    always_comb begin
        if (n_count == '0) begin
            rsp_next.top_value     = '0;
            rsp_next.top_is_number = 1'b1;
        end else begin
            rsp_next.top_value     = fds_pkg::to_field(n_top.value);
            rsp_next.top_is_number = n_top.tag;
        end
        rsp_next.stack_depth = fds_pkg::DEPTH_W'(n_count);
        rsp_next.error_code  = n_err;
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fds_pkg::ST_IDLE;
            r_count <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (emit) begin
                r_ov <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_top  <= n_top;
        r_hold <= n_hold;
        r_err  <= n_err;
        r_ptr  <= n_ptr;
        r_wa   <= n_wa;
        r_last <= n_last;
        if (i_req.valid && i_req.ready) begin
            r_act  <= i_req.data.action;
            r_pv   <= i_req.data.push_value;
            r_ptag <= i_req.data.push_is_number;
        end
        if (emit) begin
            r_rsp <= rsp_next;
        end
    end

    assign i_req.ready = r_state == fds_pkg::ST_IDLE;
    assign o_rsp.valid = r_ov;
    assign o_rsp.data  = r_rsp;

endmodule

`default_nettype wire

### src/fds_checker.sv
// Port-level checker for the data stack engine and the bind that attaches it.
// Depends on fds_pkg and on the top level forth_style_data_stack_engine.
`default_nettype none

module fds_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          i_req_valid,
    input wire logic          i_req_ready,
    input wire logic          i_rsp_valid,
    input wire logic          i_rsp_ready,
    input wire fds_pkg::t_rsp i_rsp_data
);

    logic [1:0]                 r_pending;
    logic [fds_pkg::DEPTH_W-1:0] r_last_depth;
    logic                       req_fire;
    logic                       rsp_fire;

    assign req_fire = i_req_valid && i_req_ready;
    assign rsp_fire = i_rsp_valid && i_rsp_ready;

    // Requests taken but not yet answered, and the depth of the last delivered response.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending    <= '0;
            r_last_depth <= '0;
        end else begin
            r_pending <= r_pending + 2'(req_fire) - 2'(rsp_fire);
            if (rsp_fire) begin
                r_last_depth <= i_rsp_data.stack_depth;
            end
        end
    end

    // A response only ever answers a request that was taken.
    a_rsp_has_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> r_pending != 2'd0)
        else $error("response without an outstanding request");

    // A failed word leaves the depth as the previous response reported it.
    a_error_keeps_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_rsp_data.error_code != fds_pkg::ERR_OK)
        |-> i_rsp_data.stack_depth == r_last_depth)
        else $error("error response changed the depth");

    // An empty stack reports a numeric zero on top.
    a_empty_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_rsp_data.stack_depth == '0)
        |-> (i_rsp_data.top_value == '0 && i_rsp_data.top_is_number))
        else $error("empty stack with a nonzero top");

    // The engine works on one request at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_fire |=> !i_req_ready)
        else $error("second request taken while one is under way");

    // A stalled response holds.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=> (i_rsp_valid && $stable(i_rsp_data)))
        else $error("stalled response changed");

endmodule

bind forth_style_data_stack_engine fds_checker u_fds_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_data  (o_rsp.data)
);

`default_nettype wire

### bench/forth_style_data_stack_engine_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for forth_style_data_stack_engine: random and directed stack words,
// with responses checked against a stack predictor. Depends on fds_pkg and fds_ifs.
module forth_style_data_stack_engine_tb;

    // Which copy of the predicted stack a call works on.
    localparam int SHADOW_GEN = 0;
    localparam int SHADOW_CHK = 1;

    // First code past the defined stack words.
    localparam logic [fds_pkg::ACT_W-1:0] ACT_UNUSED_LO = 4'd10;

    localparam int HOLD_CYCLES  = 300;
    localparam int QUIET_LIMIT  = 3000;
    localparam int TAIL_CYCLES  = 80;
    localparam int PRESSURE_AT  = 150;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic          req_valid = 1'b0;
    fds_pkg::t_req req_word  = '0;
    logic          rsp_ready = 1'b0;

    fds_req_if req_if ();
    fds_rsp_if rsp_if ();

    assign req_if.valid = req_valid;
    assign req_if.data  = req_word;
    assign rsp_if.ready = rsp_ready;

    forth_style_data_stack_engine uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // Two copies of the stack: one follows generation, one follows accepted requests.
    fds_pkg::t_entry shadow_stack [2][fds_pkg::STACK_DEPTH];
    int              shadow_count [2] = '{0, 0};

    fds_pkg::t_req word_queue [$];
    fds_pkg::t_rsp predicted_rsps [$];

    int            send_idle_pct = 0;
    int            recv_idle_pct = 0;
    logic          req_taken     = 1'b0;
    int            results_seen  = 0;
    int            fail_count    = 0;
    int            quiet_cycles  = 0;
    int            words_made    = 0;
    int            hold_left     = 0;
    logic          hold_done     = 1'b0;
    fds_pkg::t_rsp want;

    // 2 ns clock.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Applies one stack word to a copy of the stack and returns the response it gives.
    function automatic fds_pkg::t_rsp run_word(input int k, input fds_pkg::t_req w);
        fds_pkg::t_rsp                          r;
        fds_pkg::t_entry                        hold;
        int                                     c;
        int                                     src;
        int                                     below;
        int                                     i;
        logic                                   full;
        logic [fds_pkg::ERR_W-1:0]              err;
        logic signed [fds_pkg::VALUE_WIDTH-1:0] idx;
        c    = shadow_count[k];
        full = (c >= fds_pkg::STACK_DEPTH);
        err  = fds_pkg::ERR_OK;
        case (w.action)
            fds_pkg::ACT_PUSH: begin
                if (full) begin
                    err = fds_pkg::ERR_OVER;
                end else begin
                    shadow_stack[k][c].tag   = w.push_is_number;
                    shadow_stack[k][c].value = fds_pkg::VALUE_WIDTH'(w.push_value);
                    shadow_count[k] = c + 1;
                end
            end
            fds_pkg::ACT_DUP, fds_pkg::ACT_OVER: begin
                if (c < ((w.action == fds_pkg::ACT_DUP) ? 1 : 2)) begin
                    err = fds_pkg::ERR_UNDER;
                end else if (full) begin
                    err = fds_pkg::ERR_OVER;
                end else begin
                    shadow_stack[k][c] =
                        shadow_stack[k][(w.action == fds_pkg::ACT_DUP) ? c - 1 : c - 2];
                    shadow_count[k] = c + 1;
                end
            end
            fds_pkg::ACT_DROP: begin
                if (c < 1) err = fds_pkg::ERR_UNDER;
                else shadow_count[k] = c - 1;
            end
            fds_pkg::ACT_SWAP: begin
                if (c < 2) begin
                    err = fds_pkg::ERR_UNDER;
                end else begin
                    hold = shadow_stack[k][c-1];
                    shadow_stack[k][c-1] = shadow_stack[k][c-2];
                    shadow_stack[k][c-2] = hold;
                end
            end
            fds_pkg::ACT_ROT: begin
                if (c < 3) begin
                    err = fds_pkg::ERR_UNDER;
                end else begin
                    hold = shadow_stack[k][c-3];
                    shadow_stack[k][c-3] = shadow_stack[k][c-2];
                    shadow_stack[k][c-2] = shadow_stack[k][c-1];
                    shadow_stack[k][c-1] = hold;
                end
            end
            fds_pkg::ACT_PICK, fds_pkg::ACT_ROLL: begin
                // The index sits on top and is consumed; it counts from the entry below it.
                if (c < 1) begin
                    err = fds_pkg::ERR_UNDER;
                end else if (!shadow_stack[k][c-1].tag) begin
                    err = fds_pkg::ERR_NOTNUM;
                end else begin
                    idx   = shadow_stack[k][c-1].value;
                    below = c - 1;
                    if (idx < 0 || idx >= below) begin
                        err = fds_pkg::ERR_BOUNDS;
                    end else begin
                        src = below - 1 - int'(idx);
                        if (w.action == fds_pkg::ACT_PICK) begin
                            shadow_stack[k][c-1] = shadow_stack[k][src];
                        end else begin
                            hold = shadow_stack[k][src];
                            for (i = src; i + 2 < c; i++)
                                shadow_stack[k][i] = shadow_stack[k][i+1];
                            shadow_stack[k][c-2] = hold;
                            shadow_count[k] = c - 1;
                        end
                    end
                end
            end
            fds_pkg::ACT_CLEAR: begin
                shadow_count[k] = 0;
            end
            fds_pkg::ACT_DEPTH: begin
                if (full) begin
                    err = fds_pkg::ERR_OVER;
                end else begin
                    shadow_stack[k][c].tag   = 1'b1;
                    shadow_stack[k][c].value = fds_pkg::VALUE_WIDTH'(c);
                    shadow_count[k] = c + 1;
                end
            end
            default: begin
            end
        endcase
        if (shadow_count[k] == 0) begin
            r.top_value     = '0;
            r.top_is_number = 1'b1;
        end else begin
            r.top_value     =
                fds_pkg::FIELD_W'(signed'(shadow_stack[k][shadow_count[k]-1].value));
            r.top_is_number = shadow_stack[k][shadow_count[k]-1].tag;
        end
        r.stack_depth = fds_pkg::DEPTH_W'(shadow_count[k]);
        r.error_code  = err;
        return r;
    endfunction

    // Values biased toward the extremes of the field.
    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 9))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // One random bit for tags and ignored fields.
    function automatic logic rand_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    // Queues one request and follows it on the generation copy of the stack.
    task automatic add_word(input logic [fds_pkg::ACT_W-1:0] act, input logic [31:0] val,
                            input logic tag);
        fds_pkg::t_req w;
        w.action         = act;
        w.push_value     = val;
        w.push_is_number = tag;
        word_queue.push_back(w);
        void'(run_word(SHADOW_GEN, w));
        words_made++;
    endtask

    // Random stack words, among them pushes with random content and mostly well-formed index sequences.
    task automatic add_random_words(input int n);
        int          stop_at;
        int          d;
        int          sel;
        int          pick_sel;
        logic [31:0] idx;
        logic        idx_tag;
        stop_at = words_made + n;
        while (words_made < stop_at) begin
            d   = shadow_count[SHADOW_GEN];
            sel = $urandom_range(0, 99);
            if (d > 44 && sel < 30) begin
                add_word(fds_pkg::ACT_DROP, $urandom, rand_bit());
            end else if (sel < 30) begin
                add_word(fds_pkg::ACT_PUSH, rand_value(), $urandom_range(0, 99) < 85);
            end else if (sel < 38) begin
                add_word(fds_pkg::ACT_DUP, $urandom, rand_bit());
            end else if (sel < 48) begin
                add_word(fds_pkg::ACT_DROP, $urandom, rand_bit());
            end else if (sel < 54) begin
                add_word(fds_pkg::ACT_SWAP, $urandom, rand_bit());
            end else if (sel < 60) begin
                add_word(fds_pkg::ACT_OVER, $urandom, rand_bit());
            end else if (sel < 66) begin
                add_word(fds_pkg::ACT_ROT, $urandom, rand_bit());
            end else if (sel < 82) begin
                // Push an index, then PICK or ROLL with it.
                pick_sel = $urandom_range(0, 99);
                idx_tag  = 1'b1;
                if (pick_sel < 75 && d >= 1) begin
                    if (pick_sel < 15) idx = d - 1;
                    else if (pick_sel < 30) idx = 0;
                    else idx = $urandom_range(0, d - 1);
                end else if (pick_sel < 83) begin
                    idx = $urandom | 32'h8000_0000;
                end else if (pick_sel < 91) begin
                    idx = d + $urandom_range(0, 3);
                end else begin
                    idx     = $urandom_range(0, 3);
                    idx_tag = 1'b0;
                end
                add_word(fds_pkg::ACT_PUSH, idx, idx_tag);
                add_word((sel < 74) ? fds_pkg::ACT_PICK : fds_pkg::ACT_ROLL, $urandom,
                         rand_bit());
            end else if (sel < 84) begin
                add_word(fds_pkg::ACT_CLEAR, $urandom, rand_bit());
            end else if (sel < 88) begin
                add_word(fds_pkg::ACT_DEPTH, $urandom, rand_bit());
            end else if (sel < 90) begin
                add_word(ACT_UNUSED_LO + fds_pkg::ACT_W'($urandom_range(0, 5)), $urandom,
                         rand_bit());
            end else if (sel < 91) begin
                // Fill the stack, then try every word that grows it.
                while (shadow_count[SHADOW_GEN] < fds_pkg::STACK_DEPTH)
                    add_word(fds_pkg::ACT_PUSH, rand_value(), 1'b1);
                add_word(fds_pkg::ACT_PUSH, rand_value(), 1'b1);
                add_word(fds_pkg::ACT_DUP, $urandom, 1'b0);
                add_word(fds_pkg::ACT_OVER, $urandom, 1'b1);
                add_word(fds_pkg::ACT_DEPTH, $urandom, 1'b0);
            end else begin
                add_word(fds_pkg::ACT_W'($urandom_range(0, 15)), $urandom, rand_bit());
            end
        end
    endtask

    // Waits until every request has been taken and every response has come back.
    // Checked at the rising edge, after the driver's falling-edge updates have settled.
    task automatic wait_drained();
        while (word_queue.size() != 0 || req_valid || predicted_rsps.size() != 0)
            @(posedge i_clk);
    endtask

    // Request driver: offers the next queued request once the current one is taken.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_valid <= 1'b0;
        end else if (!req_valid || req_taken) begin
            if (word_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                req_valid <= 1'b1;
                req_word  <= word_queue.pop_front();
            end else begin
                req_valid <= 1'b0;
            end
        end
    end

    // Response sink: random stalls, plus one long hold-off to back the engine up.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
        end else if (!hold_done && results_seen >= PRESSURE_AT) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            rsp_ready <= 1'b0;
        end else begin
            rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Monitor: predicts each accepted request, checks each accepted response, watches for hangs.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            req_taken = req_if.valid && req_if.ready;
            if (req_taken)
                predicted_rsps.push_back(run_word(SHADOW_CHK, req_if.data));
            if (rsp_if.valid && rsp_if.ready) begin
                results_seen++;
                if (predicted_rsps.size() == 0) begin
                    $display("%0t: response with nothing outstanding, actual %h",
                             $time, rsp_if.data);
                    fail_count++;
                end else begin
                    want = predicted_rsps.pop_front();
                    if (rsp_if.data.top_value !== want.top_value) begin
                        $display("%0t: top_value expected %h actual %h",
                                 $time, want.top_value, rsp_if.data.top_value);
                        fail_count++;
                    end
                    if (rsp_if.data.top_is_number !== want.top_is_number) begin
                        $display("%0t: top_is_number expected %b actual %b",
                                 $time, want.top_is_number, rsp_if.data.top_is_number);
                        fail_count++;
                    end
                    if (rsp_if.data.stack_depth !== want.stack_depth) begin
                        $display("%0t: stack_depth expected %0d actual %0d",
                                 $time, want.stack_depth, rsp_if.data.stack_depth);
                        fail_count++;
                    end
                    if (rsp_if.data.error_code !== want.error_code) begin
                        $display("%0t: error_code expected %0d actual %0d",
                                 $time, want.error_code, rsp_if.data.error_code);
                        fail_count++;
                    end
                end
            end
            if (req_taken || (rsp_if.valid && rsp_if.ready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no request or response moved for %0d cycles",
                         $time, quiet_cycles);
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Stimulus sequence and end of run.
    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Sender mostly busy, receiver mostly stalled.
        send_idle_pct = 13;
        recv_idle_pct = 82;

        // Directed words: underflow on an empty stack, extreme values, every word,
        // unused codes and each index error.
        add_word(fds_pkg::ACT_DROP,  32'h0, 1'b1);
        add_word(fds_pkg::ACT_PICK,  32'h0, 1'b1);
        add_word(fds_pkg::ACT_ROT,   32'h0, 1'b1);
        add_word(fds_pkg::ACT_PUSH,  32'h7fff_ffff, 1'b1);
        add_word(fds_pkg::ACT_PUSH,  32'h8000_0000, 1'b0);
        add_word(fds_pkg::ACT_PUSH,  32'hffff_ffff, 1'b1);
        add_word(fds_pkg::ACT_PUSH,  32'h0000_0000, 1'b1);
        add_word(fds_pkg::ACT_DEPTH, 32'hffff_ffff, 1'b0);
        add_word(fds_pkg::ACT_SWAP,  32'h0, 1'b0);
        add_word(fds_pkg::ACT_OVER,  32'h0, 1'b0);
        add_word(fds_pkg::ACT_ROT,   32'h0, 1'b0);
        add_word(fds_pkg::ACT_DUP,   32'h0, 1'b0);
        add_word(ACT_UNUSED_LO + 4'd5, 32'hffff_ffff, 1'b1);
        // Negative index, index too large, then a non-numeric index.
        add_word(fds_pkg::ACT_PUSH,  32'hffff_ffff, 1'b1);
        add_word(fds_pkg::ACT_PICK,  32'h0, 1'b1);
        add_word(fds_pkg::ACT_PUSH,  32'd100, 1'b1);
        add_word(fds_pkg::ACT_ROLL,  32'h0, 1'b1);
        add_word(fds_pkg::ACT_PUSH,  32'd2, 1'b0);
        add_word(fds_pkg::ACT_PICK,  32'h0, 1'b1);
        // Valid PICK and ROLL, ROLL 0, then CLEAR.
        add_word(fds_pkg::ACT_PUSH,  32'd2, 1'b1);
        add_word(fds_pkg::ACT_PICK,  32'h0, 1'b1);
        add_word(fds_pkg::ACT_PUSH,  32'd3, 1'b1);
        add_word(fds_pkg::ACT_ROLL,  32'h0, 1'b1);
        add_word(fds_pkg::ACT_PUSH,  32'd0, 1'b1);
        add_word(fds_pkg::ACT_ROLL,  32'h0, 1'b1);
        add_word(fds_pkg::ACT_CLEAR, 32'h0, 1'b1);

        add_random_words(480);
        wait_drained();

        // Sender mostly idle, receiver mostly ready.
        send_idle_pct = 82;
        recv_idle_pct = 13;
        add_random_words(500);
        wait_drained();

        // Neither side idles.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        add_random_words(500);
        wait_drained();

        // Let any stray response show up before the verdict.
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### files.f
src/fds_pkg.sv
src/fds_ifs.sv
src/fds_ram.sv
src/forth_style_data_stack_engine.sv
src/fds_checker.sv
bench/forth_style_data_stack_engine_tb.sv
